@@ hdl/cdbp_pkg.sv @@
package cdbp_pkg;

    localparam int unsigned BLOCK_BYTES = 128;
    localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] FIRST_HDR = POS_W'(4);
    localparam logic [POS_W-1:0] END_POS   = POS_W'(2);

    localparam logic [4:0] MAX_AUDIO_BLOCK_BYTES = 5'd30;
    localparam logic [2:0] MAX_AUDIO_BLOCKS      = 3'd5;
    localparam logic [4:0] SPEAKER_BYTES         = 5'd3;

    localparam logic [7:0]  CEA_TAG = 8'h02;
    localparam logic [23:0] HF_OUI  = 24'hC45DD8;

    localparam logic [2:0] TAG_AUDIO   = 3'd1;
    localparam logic [2:0] TAG_VENDOR  = 3'd3;
    localparam logic [2:0] TAG_SPEAKER = 3'd4;

    localparam logic KIND_AUDIO   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  audio_byte;
        logic [7:0]  audio_total;
        logic [23:0] speaker_payload;
        logic        speaker_valid;
        logic [2:0]  deep_color;
        logic        cea_found;
        logic        last;
    } t_result;

endpackage

@@ hdl/cea_data_block_parser_unit.sv @@
// Parses one 128-byte EDID extension block, one byte per input transaction, byte 0 first
// (i_first restarts the parse at any byte). For a CEA extension it streams out the short
// audio descriptor bytes as they arrive and, after byte 127 of any block, a summary with the
// audio byte count, the first speaker allocation block and the HF-VSDB Y420 deep color bits.
// One byte is taken every clock cycle while o_in_ready is high: the byte updates the walk
// state and forms its results in the accepting cycle, and those results enter a four-entry
// result queue, read out in order. o_in_ready drops only while fewer than two queue entries
// are free; a byte makes at most two results and a summary comes once per 128 bytes.
module cea_data_block_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_audio_byte,
    output logic [7:0]  o_audio_total,
    output logic [23:0] o_speaker_payload,
    output logic        o_speaker_valid,
    output logic [2:0]  o_deep_color,
    output logic        o_cea_found,
    output logic        o_last
);
    import cdbp_pkg::*;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // parse state
    logic [POS_W-1:0] r_byte_position, n_byte_position;
    logic             r_is_cea, n_is_cea;
    logic [6:0]       r_audio_end, n_audio_end;
    logic [6:0]       r_color_end, n_color_end;
    logic [7:0]       r_next_header, n_next_header;
    logic [4:0]       r_payload_left, n_payload_left;
    logic [2:0]       r_block_tag, n_block_tag;
    logic [4:0]       r_payload_index, n_payload_index;
    logic             r_audio_walk_on, n_audio_walk_on;
    logic             r_color_walk_on, n_color_walk_on;
    logic             r_copying_audio, n_copying_audio;
    logic [2:0]       r_audio_blocks, n_audio_blocks;
    logic [7:0]       r_audio_count, n_audio_count;
    logic             r_speaker_seen, n_speaker_seen;
    logic             r_speaker_ok, n_speaker_ok;
    logic [23:0]      r_speaker_bytes, n_speaker_bytes;
    logic [23:0]      r_oui_match, n_oui_match;
    logic [2:0]       r_color_flags, n_color_flags;
    logic             r_audio_stopped, n_audio_stopped;
    logic             r_speaker_cap, n_speaker_cap;
    logic             r_hf_cap, n_hf_cap;

    // result queue
    t_result            r_queue [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    t_result            w_res0, w_res1;
    logic [1:0]         w_push_n;
    logic               w_in_fire, w_out_fire;

    assign o_in_ready  = (r_count <= QCNT_W'(QDEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = o_out_valid && i_out_ready;

    always_comb begin
        logic [POS_W-1:0] w_pos;
        logic [4:0]       w_idx;
        logic [4:0]       w_len;
        logic [2:0]       w_tag;
        logic [7:0]       w_pos8;
        logic [7:0]       w_reach;
        logic             w_audio_res;

        n_is_cea        = r_is_cea;
        n_audio_end     = r_audio_end;
        n_color_end     = r_color_end;
        n_next_header   = r_next_header;
        n_payload_left  = r_payload_left;
        n_block_tag     = r_block_tag;
        n_payload_index = r_payload_index;
        n_audio_walk_on = r_audio_walk_on;
        n_color_walk_on = r_color_walk_on;
        n_copying_audio = r_copying_audio;
        n_audio_blocks  = r_audio_blocks;
        n_audio_count   = r_audio_count;
        n_speaker_seen  = r_speaker_seen;
        n_speaker_ok    = r_speaker_ok;
        n_speaker_bytes = r_speaker_bytes;
        n_oui_match     = r_oui_match;
        n_color_flags   = r_color_flags;
        n_audio_stopped = r_audio_stopped;
        n_speaker_cap   = r_speaker_cap;
        n_hf_cap        = r_hf_cap;
        w_audio_res     = 1'b0;

        w_pos   = i_first ? '0 : r_byte_position;
        w_idx   = r_payload_index + 5'd1;
        w_len   = i_data_byte[4:0];
        w_tag   = i_data_byte[7:5];
        w_pos8  = {1'b0, w_pos};
        w_reach = w_pos8 + {3'b0, w_len};

        if (w_pos == '0) begin
            n_is_cea        = (i_data_byte == CEA_TAG);
            n_audio_end     = '0;
            n_color_end     = '0;
            n_next_header   = 8'(FIRST_HDR);
            n_payload_left  = '0;
            n_block_tag     = '0;
            n_payload_index = '0;
            n_audio_walk_on = n_is_cea;
            n_color_walk_on = n_is_cea;
            n_copying_audio = 1'b0;
            n_audio_blocks  = '0;
            n_audio_count   = '0;
            n_speaker_seen  = 1'b0;
            n_speaker_ok    = 1'b0;
            n_speaker_bytes = '0;
            n_oui_match     = '0;
            n_color_flags   = '0;
            n_audio_stopped = 1'b0;
            n_speaker_cap   = 1'b0;
            n_hf_cap        = 1'b0;
        end else if (w_pos == END_POS) begin
            if (i_data_byte == 8'd0 || i_data_byte == 8'd4) begin
                n_audio_end = '0;
            end else if (i_data_byte[7]) begin
                n_audio_end = 7'd127;
            end else begin
                n_audio_end = i_data_byte[6:0];
            end
            // zero means the collection runs to the checksum
            if (i_data_byte == 8'd0) begin
                n_color_end = 7'd127;
            end else if (i_data_byte < 8'd4 || i_data_byte[7]) begin
                n_color_end     = '0;
                n_color_walk_on = 1'b0;
            end else begin
                n_color_end = i_data_byte[6:0];
            end
        end else if (w_pos >= FIRST_HDR && r_is_cea) begin
            if (r_payload_left != '0) begin
                n_payload_index = w_idx;
                if (r_copying_audio) begin
                    n_audio_count = r_audio_count + 8'd1;
                    w_audio_res   = 1'b1;
                end
                if (r_speaker_cap) begin
                    case (w_idx)
                        5'd1:    n_speaker_bytes[7:0]   = r_speaker_bytes[7:0] | i_data_byte;
                        5'd2:    n_speaker_bytes[15:8]  = r_speaker_bytes[15:8] | i_data_byte;
                        5'd3:    n_speaker_bytes[23:16] = r_speaker_bytes[23:16] | i_data_byte;
                        default: ;
                    endcase
                end
                if (r_hf_cap) begin
                    case (w_idx)
                        5'd1:    n_oui_match[7:0]   = r_oui_match[7:0] | i_data_byte;
                        5'd2:    n_oui_match[15:8]  = r_oui_match[15:8] | i_data_byte;
                        5'd3:    n_oui_match[23:16] = r_oui_match[23:16] | i_data_byte;
                        5'd7: begin
                            if (r_oui_match == HF_OUI) begin
                                n_color_flags = r_color_flags | i_data_byte[2:0];
                            end
                        end
                        default: ;
                    endcase
                end
                n_payload_left = r_payload_left - 5'd1;
                if (n_payload_left == '0) begin
                    n_copying_audio = 1'b0;
                    n_speaker_cap   = 1'b0;
                    n_hf_cap        = 1'b0;
                end
            end else if (w_pos8 == r_next_header) begin
                // data block header
                n_block_tag     = w_tag;
                n_payload_left  = w_len;
                n_payload_index = '0;
                n_next_header   = w_reach + 8'd1;
                n_copying_audio = 1'b0;
                n_speaker_cap   = 1'b0;
                n_hf_cap        = 1'b0;
                if (r_audio_walk_on) begin
                    if (w_pos >= r_audio_end) begin
                        n_audio_walk_on = 1'b0;
                    end else if (w_reach <= {1'b0, r_audio_end}) begin
                        if (w_tag == TAG_AUDIO && !r_audio_stopped) begin
                            if (w_len > MAX_AUDIO_BLOCK_BYTES ||
                                r_audio_blocks >= MAX_AUDIO_BLOCKS) begin
                                n_audio_stopped = 1'b1;
                            end else begin
                                n_audio_blocks  = r_audio_blocks + 3'd1;
                                n_copying_audio = (w_len != '0);
                            end
                        end
                        if (w_tag == TAG_SPEAKER && !r_speaker_seen) begin
                            n_speaker_seen = 1'b1;
                            n_speaker_ok   = (w_len == SPEAKER_BYTES);
                            n_speaker_cap  = (w_len == SPEAKER_BYTES);
                        end
                    end
                end
                if (r_color_walk_on) begin
                    if (w_pos < r_color_end && w_reach < {1'b0, r_color_end}) begin
                        if (w_tag == TAG_VENDOR && w_len >= 5'd7) begin
                            n_hf_cap    = 1'b1;
                            n_oui_match = '0;
                        end
                    end else begin
                        n_color_walk_on = 1'b0;
                    end
                end
            end
        end

        n_byte_position = w_pos + POS_W'(1);

        w_res0 = '{kind: KIND_AUDIO, audio_byte: i_data_byte, audio_total: n_audio_count,
                   speaker_payload: '0, speaker_valid: 1'b0, deep_color: '0,
                   cea_found: n_is_cea, last: 1'b0};
        w_res1 = '{kind: KIND_SUMMARY, audio_byte: '0, audio_total: n_audio_count,
                   speaker_payload: n_speaker_bytes, speaker_valid: n_speaker_ok,
                   deep_color: n_color_flags, cea_found: n_is_cea, last: 1'b1};
        w_push_n = '0;
        if (w_pos == LAST_POS) begin
            if (w_audio_res) begin
                w_push_n = 2'd2;
            end else begin
                w_res0   = w_res1;
                w_push_n = 2'd1;
            end
        end else if (w_audio_res) begin
            w_push_n = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_is_cea        <= 1'b0;
            r_audio_end     <= '0;
            r_color_end     <= '0;
            r_next_header   <= 8'(FIRST_HDR);
            r_payload_left  <= '0;
            r_block_tag     <= '0;
            r_payload_index <= '0;
            r_audio_walk_on <= 1'b1;
            r_color_walk_on <= 1'b1;
            r_copying_audio <= 1'b0;
            r_audio_blocks  <= '0;
            r_audio_count   <= '0;
            r_speaker_seen  <= 1'b0;
            r_speaker_ok    <= 1'b0;
            r_speaker_bytes <= '0;
            r_oui_match     <= '0;
            r_color_flags   <= '0;
            r_audio_stopped <= 1'b0;
            r_speaker_cap   <= 1'b0;
            r_hf_cap        <= 1'b0;
        end else if (w_in_fire) begin
            r_byte_position <= n_byte_position;
            r_is_cea        <= n_is_cea;
            r_audio_end     <= n_audio_end;
            r_color_end     <= n_color_end;
            r_next_header   <= n_next_header;
            r_payload_left  <= n_payload_left;
            r_block_tag     <= n_block_tag;
            r_payload_index <= n_payload_index;
            r_audio_walk_on <= n_audio_walk_on;
            r_color_walk_on <= n_color_walk_on;
            r_copying_audio <= n_copying_audio;
            r_audio_blocks  <= n_audio_blocks;
            r_audio_count   <= n_audio_count;
            r_speaker_seen  <= n_speaker_seen;
            r_speaker_ok    <= n_speaker_ok;
            r_speaker_bytes <= n_speaker_bytes;
            r_oui_match     <= n_oui_match;
            r_color_flags   <= n_color_flags;
            r_audio_stopped <= n_audio_stopped;
            r_speaker_cap   <= n_speaker_cap;
            r_hf_cap        <= n_hf_cap;
        end
    end

    // result queue, up to two writes and one read per cycle
    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= w_res0;
        end
        if (w_in_fire && w_push_n == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_in_fire) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(w_push_n);
            end
            if (w_out_fire) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (w_in_fire ? QCNT_W'(w_push_n) : '0)
                       - QCNT_W'(w_out_fire);
        end
    end

    assign o_kind            = r_queue[r_rd_ptr].kind;
    assign o_audio_byte      = r_queue[r_rd_ptr].audio_byte;
    assign o_audio_total     = r_queue[r_rd_ptr].audio_total;
    assign o_speaker_payload = r_queue[r_rd_ptr].speaker_payload;
    assign o_speaker_valid   = r_queue[r_rd_ptr].speaker_valid;
    assign o_deep_color      = r_queue[r_rd_ptr].deep_color;
    assign o_cea_found       = r_queue[r_rd_ptr].cea_found;
    assign o_last            = r_queue[r_rd_ptr].last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_count <= QCNT_W'(QDEPTH - 2)))
        else $error("ready without room for two results");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == o_kind))
        else $error("summary flag and kind disagree");

    a_audio_cea: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_AUDIO) |-> (o_cea_found && o_deep_color == '0))
        else $error("audio result outside a CEA block");

    a_audio_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_audio_count <= 8'(MAX_AUDIO_BLOCKS) * 8'(MAX_AUDIO_BLOCK_BYTES))
        else $error("audio byte count beyond block limits");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_count == '0 && !o_out_valid))
        else $error("result queue not empty after reset");

endmodule

@@ test/cea_data_block_parser_unit_tb.sv @@
`timescale 1ns / 1ps

module cea_data_block_parser_unit_tb;
    import cdbp_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned PHASE_BYTES  = 100;
    localparam int unsigned DRAIN_CYCLES = 16;

    // payload index of the y420 deep color byte in an hf-vsdb, also its minimum length
    localparam int unsigned HF_FLAGS_IDX = 7;
    localparam int unsigned OUI_BYTES    = 3;
    localparam logic [2:0]  TAG_VIDEO    = 3'd2;
    localparam logic [2:0]  TAG_EXTENDED = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first     = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_kind;
    logic [7:0]  o_audio_byte;
    logic [7:0]  o_audio_total;
    logic [23:0] o_speaker_payload;
    logic        o_speaker_valid;
    logic [2:0]  o_deep_color;
    logic        o_cea_found;
    logic        o_last;

    cea_data_block_parser_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_first           (i_first),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_audio_byte      (o_audio_byte),
        .o_audio_total     (o_audio_total),
        .o_speaker_payload (o_speaker_payload),
        .o_speaker_valid   (o_speaker_valid),
        .o_deep_color      (o_deep_color),
        .o_cea_found       (o_cea_found),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned errors             = 0;
    int unsigned bytes_sent         = 0;
    int unsigned audio_seen         = 0;
    int unsigned summaries_seen     = 0;
    int unsigned idle_cycles        = 0;

    // parser walk state, mirrored from the block
    t_result     expected_q[$];
    logic [6:0]  byte_pos = '0;
    logic        cea_seen;
    logic [6:0]  audio_limit;
    logic [6:0]  color_limit;
    logic [7:0]  header_pos;
    logic [4:0]  bytes_left;
    logic [4:0]  payload_idx;
    logic        audio_walk;
    logic        color_walk;
    logic        audio_copy;
    logic        audio_halt;
    logic        speaker_cap;
    logic        hf_cap;
    logic [2:0]  audio_blocks;
    logic [7:0]  audio_count;
    logic        speaker_seen;
    logic        speaker_ok;
    logic [23:0] speaker_bytes;
    logic [23:0] oui_bytes;
    logic [2:0]  color_flags;

    // extension block under construction
    logic [7:0]  blk [BLOCK_BYTES];
    int unsigned fill_pos;

    function automatic void clear_walk();
        cea_seen      = 1'b0;
        audio_limit   = '0;
        color_limit   = '0;
        header_pos    = 8'(FIRST_HDR);
        bytes_left    = '0;
        payload_idx   = '0;
        audio_walk    = 1'b1;
        color_walk    = 1'b1;
        audio_copy    = 1'b0;
        audio_halt    = 1'b0;
        speaker_cap   = 1'b0;
        hf_cap        = 1'b0;
        audio_blocks  = '0;
        audio_count   = '0;
        speaker_seen  = 1'b0;
        speaker_ok    = 1'b0;
        speaker_bytes = '0;
        oui_bytes     = '0;
        color_flags   = '0;
    endfunction

    function automatic void push_result(logic kind, logic [7:0] ab);
        t_result r;
        r.kind            = kind;
        r.audio_byte      = ab;
        r.audio_total     = audio_count;
        r.speaker_payload = (kind == KIND_SUMMARY) ? speaker_bytes : '0;
        r.speaker_valid   = (kind == KIND_SUMMARY) ? speaker_ok : 1'b0;
        r.deep_color      = (kind == KIND_SUMMARY) ? color_flags : '0;
        r.cea_found       = cea_seen;
        r.last            = kind;
        expected_q.push_back(r);
    endfunction

    function automatic void open_header(int unsigned p, logic [7:0] b);
        int unsigned len;
        logic [2:0]  tag;
        len         = b[4:0];
        tag         = b[7:5];
        bytes_left  = b[4:0];
        payload_idx = '0;
        header_pos  = 8'(p + 1 + len);
        audio_copy  = 1'b0;
        speaker_cap = 1'b0;
        hf_cap      = 1'b0;
        if (audio_walk) begin
            if (p >= audio_limit) begin
                audio_walk = 1'b0;
            end else if (p + len <= audio_limit) begin
                if (tag == TAG_AUDIO && !audio_halt) begin
                    if (len > MAX_AUDIO_BLOCK_BYTES || audio_blocks >= MAX_AUDIO_BLOCKS) begin
                        audio_halt = 1'b1;
                    end else begin
                        audio_blocks = audio_blocks + 3'd1;
                        audio_copy   = (len > 0);
                    end
                end
                if (tag == TAG_SPEAKER && !speaker_seen) begin
                    speaker_seen = 1'b1;
                    speaker_ok   = (len == SPEAKER_BYTES);
                    speaker_cap  = speaker_ok;
                end
            end
        end
        if (color_walk) begin
            if (p < color_limit && p + len < color_limit) begin
                if (tag == TAG_VENDOR && len >= HF_FLAGS_IDX) begin
                    hf_cap    = 1'b1;
                    oui_bytes = '0;
                end
            end else begin
                color_walk = 1'b0;
            end
        end
    endfunction

    // advance the walk by one byte and queue whatever it produces
    function automatic void parse_byte(logic [7:0] b, logic f);
        int unsigned p;
        p = f ? 0 : byte_pos;
        if (p == 0) begin
            clear_walk();
            cea_seen   = (b == CEA_TAG);
            audio_walk = cea_seen;
            color_walk = cea_seen;
        end else if (p == END_POS) begin
            if (b == 0 || b == FIRST_HDR)
                audio_limit = '0;
            else
                audio_limit = (b > LAST_POS) ? LAST_POS : b[6:0];
            if (b == 0) begin
                color_limit = LAST_POS;
            end else if (b < FIRST_HDR || b > LAST_POS) begin
                color_limit = '0;
                color_walk  = 1'b0;
            end else begin
                color_limit = b[6:0];
            end
        end else if (p >= FIRST_HDR && cea_seen) begin
            if (bytes_left != 0) begin
                payload_idx = payload_idx + 5'd1;
                if (audio_copy) begin
                    audio_count = audio_count + 8'd1;
                    push_result(KIND_AUDIO, b);
                end
                if (speaker_cap && payload_idx >= 1 && payload_idx <= SPEAKER_BYTES)
                    speaker_bytes |= 24'(b) << (8 * (payload_idx - 1));
                if (hf_cap) begin
                    if (payload_idx >= 1 && payload_idx <= OUI_BYTES)
                        oui_bytes |= 24'(b) << (8 * (payload_idx - 1));
                    if (payload_idx == HF_FLAGS_IDX && oui_bytes == HF_OUI)
                        color_flags |= b[2:0];
                end
                bytes_left = bytes_left - 5'd1;
                if (bytes_left == 0) begin
                    audio_copy  = 1'b0;
                    speaker_cap = 1'b0;
                    hf_cap      = 1'b0;
                end
            end else if (p == header_pos) begin
                open_header(p, b);
            end
        end
        if (p == LAST_POS)
            push_result(KIND_SUMMARY, 8'h00);
        byte_pos = 7'(p + 1);
    endfunction

    function automatic void start_block(logic [7:0] end_byte);
        foreach (blk[i])
            blk[i] = 8'($urandom);
        blk[0]   = CEA_TAG;
        blk[2]   = end_byte;
        fill_pos = FIRST_HDR;
    endfunction

    // header plus random payload; hf puts the hf-vsdb oui and deep color bits in
    function automatic void add_block(logic [2:0] tag, int unsigned len, logic hf,
                                      logic [2:0] flags);
        if (fill_pos > LAST_POS)
            return;
        blk[fill_pos] = {tag, 5'(len)};
        if (tag == TAG_VENDOR && hf) begin
            for (int k = 1; k <= OUI_BYTES; k++)
                if (fill_pos + k <= LAST_POS)
                    blk[fill_pos + k] = HF_OUI[8 * (k - 1) +: 8];
            if (len >= HF_FLAGS_IDX && fill_pos + HF_FLAGS_IDX <= LAST_POS)
                blk[fill_pos + HF_FLAGS_IDX][2:0] = flags;
        end
        fill_pos += len + 1;
    endfunction

    function automatic logic [7:0] pick_end();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'(FIRST_HDR);
            2:       return 8'($urandom_range(3, 1));
            3:       return 8'($urandom_range(255, 128));
            4:       return 8'(LAST_POS);
            default: return 8'($urandom_range(127, 5));
        endcase
    endfunction

    // well-formed collection with random lengths, mostly audio, speaker and hf-vsdb blocks
    function automatic void make_random_block(logic [7:0] end_byte);
        int unsigned pick;
        int unsigned len;
        logic [2:0]  tag;
        start_block(end_byte);
        while (fill_pos <= LAST_POS) begin
            pick = $urandom_range(19);
            if (pick < 8)
                tag = TAG_AUDIO;
            else if (pick < 11)
                tag = TAG_SPEAKER;
            else if (pick < 15)
                tag = TAG_VENDOR;
            else
                tag = 3'($urandom);
            case (tag)
                TAG_AUDIO:
                    len = ($urandom_range(9) == 0) ? $urandom_range(31)
                                                   : 3 * $urandom_range(10);
                TAG_SPEAKER:
                    len = ($urandom_range(4) == 0) ? $urandom_range(31) : SPEAKER_BYTES;
                TAG_VENDOR:
                    len = ($urandom_range(5) == 0) ? $urandom_range(31)
                                                   : $urandom_range(31, HF_FLAGS_IDX);
                default:
                    len = $urandom_range(31);
            endcase
            add_block(tag, len, $urandom_range(4) != 0, 3'($urandom));
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic f);
        int unsigned gap;
        gap = 0;
        if (sender_idle_pct != 0)
            while ($urandom_range(99) < sender_idle_pct)
                gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_first     <= f;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        parse_byte(b, f);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_block(int unsigned n, logic first_flag);
        for (int unsigned i = 0; i < n; i++)
            send_byte(blk[i], (i == 0) ? first_flag : 1'b0);
    endtask

    // first byte after reset starts a block even without the first flag
    task automatic test_reset_start();
        foreach (blk[i])
            blk[i] = 8'($urandom);
        if (blk[0] == CEA_TAG)
            blk[0] = ~CEA_TAG;
        send_block(BLOCK_BYTES, 1'b0);
    endtask

    // every field populated, 48-bit flag set, last byte also an audio byte
    task automatic test_full_block();
        start_block(8'(LAST_POS));
        add_block(TAG_AUDIO, 3, 1'b0, 3'b000);
        add_block(TAG_SPEAKER, SPEAKER_BYTES, 1'b0, 3'b000);
        add_block(TAG_VENDOR, HF_FLAGS_IDX, 1'b1, 3'b111);
        add_block(TAG_AUDIO, MAX_AUDIO_BLOCK_BYTES, 1'b0, 3'b000);
        add_block(TAG_AUDIO, 0, 1'b0, 3'b000);
        add_block(TAG_AUDIO, 6, 1'b0, 3'b000);
        add_block(TAG_VIDEO, 31, 1'b0, 3'b000);
        add_block(TAG_EXTENDED, 31, 1'b0, 3'b000);
        add_block(TAG_AUDIO, LAST_POS - fill_pos, 1'b0, 3'b000);
        send_block(BLOCK_BYTES, 1'b1);
    endtask

    task automatic test_audio_stops();
        // oversized block halts extraction, bad speaker length, short or foreign vsdb
        start_block(8'(LAST_POS));
        add_block(TAG_AUDIO, 6, 1'b0, 3'b000);
        add_block(TAG_AUDIO, 31, 1'b0, 3'b000);
        add_block(TAG_AUDIO, 3, 1'b0, 3'b000);
        add_block(TAG_SPEAKER, 2, 1'b0, 3'b000);
        add_block(TAG_SPEAKER, SPEAKER_BYTES, 1'b0, 3'b000);
        add_block(TAG_VENDOR, HF_FLAGS_IDX, 1'b0, 3'b000);
        add_block(TAG_VENDOR, HF_FLAGS_IDX - 1, 1'b1, 3'b111);
        send_block(BLOCK_BYTES, 1'b1);
        // block count limit, and flags from two hf-vsdbs are merged
        start_block(8'(LAST_POS));
        repeat (MAX_AUDIO_BLOCKS + 2)
            add_block(TAG_AUDIO, 1, 1'b0, 3'b000);
        add_block(TAG_VENDOR, 12, 1'b1, 3'b001);
        add_block(TAG_VENDOR, 9, 1'b1, 3'b010);
        send_block(BLOCK_BYTES, 1'b1);
    endtask

    task automatic test_end_limits();
        logic [7:0] ends [8];
        ends = '{8'h00, 8'(FIRST_HDR), 8'h01, 8'(END_POS), 8'h03, 8'd20, 8'h80, 8'hFF};
        foreach (ends[i]) begin
            make_random_block(ends[i]);
            send_block(BLOCK_BYTES, 1'b1);
        end
    endtask

    task automatic test_wrap_restart();
        make_random_block(8'(LAST_POS));
        send_block(BLOCK_BYTES, 1'b1);
        // byte 0 taken from the position wrap, no first flag
        make_random_block(8'(LAST_POS));
        send_block(BLOCK_BYTES, 1'b0);
        // cut short and restarted by the first flag
        make_random_block(8'(LAST_POS));
        send_block(60, 1'b1);
        make_random_block(8'(LAST_POS));
        send_block(BLOCK_BYTES, 1'b1);
    endtask

    task automatic test_random_traffic(int unsigned in_pct, int unsigned out_pct);
        int unsigned start_count;
        int unsigned n;
        sender_idle_pct    = in_pct;
        receiver_stall_pct = out_pct;
        start_count        = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES) begin
            case ($urandom_range(9))
                0: begin
                    foreach (blk[i])
                        blk[i] = 8'($urandom);
                end
                1: begin
                    foreach (blk[i])
                        blk[i] = 8'($urandom);
                    blk[0] = CEA_TAG;
                end
                default: make_random_block(pick_end());
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(127, 1) : BLOCK_BYTES;
            send_block(n, $urandom_range(6) != 0);
        end
    endtask

    always @(negedge i_clk)
        i_out_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);

    function automatic void compare_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_kind, o_audio_byte, o_audio_total, o_speaker_payload, o_speaker_valid,
                   o_deep_color, o_cea_found, o_last};
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, got 0x%0h", $time, got);
            end else begin
                want = expected_q.pop_front();
                if (want.kind == KIND_SUMMARY)
                    summaries_seen++;
                else
                    audio_seen++;
                compare_field("kind", 24'(want.kind), 24'(got.kind));
                compare_field("audio_byte", 24'(want.audio_byte), 24'(got.audio_byte));
                compare_field("audio_total", 24'(want.audio_total), 24'(got.audio_total));
                compare_field("speaker_payload", want.speaker_payload, got.speaker_payload);
                compare_field("speaker_valid", 24'(want.speaker_valid),
                              24'(got.speaker_valid));
                compare_field("deep_color", 24'(want.deep_color), 24'(got.deep_color));
                compare_field("cea_found", 24'(want.cea_found), 24'(got.cea_found));
                compare_field("last", 24'(want.last), 24'(got.last));
            end
        end
    end

    // ends the run when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_q.size());
            $display("cea_data_block_parser_unit_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_start();
        test_full_block();
        test_audio_stops();
        test_end_limits();
        test_wrap_restart();
        test_random_traffic(0, 0);
        test_random_traffic(81, 0);
        test_random_traffic(0, 81);
        test_random_traffic(17, 17);

        i_in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d extension bytes; checked %0d audio descriptor bytes, %0d summaries",
                 bytes_sent, audio_seen, summaries_seen);
        $display("flow control phases: none, sender gaps, receiver stalls, both; %0d errors",
                 errors);
        if (errors == 0 && expected_q.size() == 0)
            $display("cea_data_block_parser_unit_tb: PASS");
        else
            $display("cea_data_block_parser_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cdbp_pkg.sv
hdl/cea_data_block_parser_unit.sv
test/cea_data_block_parser_unit_tb.sv
